/* design/psub_pkg.sv */
// Shared types and constants for the palette sprite upscale blitter.
// Holds item kinds, register indexes and the queue entry layout; no dependencies.
package psub_pkg;

  localparam int ADDR_W      = 14;
  localparam int CHAN_W      = 8;
  localparam int RGB_W       = 3 * CHAN_W;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int ORIGIN_X_W  = 9;
  localparam int ORIGIN_Y_W  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // target pixels of one 2x2 block, in write order
  localparam int TGT_X0_Y0 = 0;
  localparam int TGT_X1_Y0 = 1;
  localparam int TGT_X0_Y1 = 2;
  localparam int TGT_X1_Y1 = 3;
  localparam int TGT_N     = 4;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ENTRY = 2'd1,
    FUNC_PIXEL = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 1'b0,
    REG_ORIGIN_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [RGB_W-1:0]  rgb;
    logic [TGT_N-1:0]  mask;
  } blit_entry_t;

endpackage

/* design/psub_front.sv */
// Front end: accepts words, keeps the palette, origin and source position,
// and turns each visible pixel into a clipped queue entry. Uses psub_pkg.
module psub_front #(
  parameter int SCREEN_W        = 160,
  parameter int SCREEN_H        = 80,
  parameter int SOURCE_W        = 80,
  parameter int SOURCE_H        = 40,
  parameter int PALETTE_ENTRIES = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [1:0]                          func,
  input  logic [5:0]                          palette_index,
  input  logic [psub_pkg::CHAN_W-1:0]         red,
  input  logic [psub_pkg::CHAN_W-1:0]         green,
  input  logic [psub_pkg::CHAN_W-1:0]         blue,
  input  logic [7:0]                          pixel_code,
  input  logic                                frame_start,
  input  logic                                cfg_write,
  input  logic [psub_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psub_pkg::CFG_W-1:0]          cfg_data,
  input  logic [psub_pkg::QLVL_W-1:0]         q_level,
  output logic                                q_push,
  output psub_pkg::blit_entry_t               q_entry
);

  localparam int CW  = (SOURCE_W > 1) ? $clog2(SOURCE_W) : 1;
  localparam int RW  = $clog2(SOURCE_H + 1);
  localparam int PIW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int XW  = $clog2(2 * SOURCE_W + SCREEN_W + 512) + 1;
  localparam int YW  = $clog2(2 * SOURCE_H + SCREEN_H + 256) + 1;
  localparam int SWB = $clog2(SCREEN_W + 1);
  localparam int PM0 = (YW + SWB > XW) ? YW + SWB : XW;
  localparam int PW  = ((PM0 > psub_pkg::ADDR_W) ? PM0 : psub_pkg::ADDR_W) + 2;

  logic [psub_pkg::RGB_W-1:0]      palette [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]      pal_valid;
  logic signed [psub_pkg::ORIGIN_X_W-1:0] origin_x;
  logic signed [psub_pkg::ORIGIN_Y_W-1:0] origin_y;
  logic [CW-1:0]                   col;
  logic [RW-1:0]                   row;
  logic [CW-1:0]                   col_next;
  logic [RW-1:0]                   row_next;
  logic [CW-1:0]                   col_e;
  logic [RW-1:0]                   row_e;
  logic                            past;
  logic                            far;
  logic                            code_ok;
  logic                            idx_ok;
  logic [PIW-1:0]                  rd_addr;
  logic [PIW-1:0]                  wr_addr;
  logic                            accept;
  psub_pkg::func_t                 kind;
  logic signed [XW-1:0]            ox;
  logic signed [XW-1:0]            sw_s;

  logic                            s1_valid;
  logic [CW-1:0]                   s1_col;
  logic [RW-1:0]                   s1_row;
  logic [psub_pkg::RGB_W-1:0]      s1_rgb;
  logic                            s1_pal_ok;

  logic signed [XW-1:0]            bx0;
  logic signed [XW-1:0]            bx1;
  logic signed [YW-1:0]            by0;
  logic signed [YW-1:0]            by1;
  logic                            x0_in;
  logic                            x1_in;
  logic                            y0_in;
  logic                            y1_in;
  logic signed [PW-1:0]            base;
  logic [psub_pkg::TGT_N-1:0]      mask;
  logic                            visible;

  assign item_ready = ({1'b0, q_level} + (psub_pkg::QLVL_W + 1)'(s1_valid))
                      < (psub_pkg::QLVL_W + 1)'(psub_pkg::QUEUE_DEPTH);
  assign accept     = item_valid && item_ready;
  assign kind       = psub_pkg::func_t'(func);

  always_comb begin
    col_e    = frame_start ? '0 : col;
    row_e    = frame_start ? '0 : row;
    past     = (row_e == RW'(SOURCE_H));
    if (col_e == CW'(SOURCE_W - 1)) begin
      col_next = '0;
      row_next = row_e + RW'(1);
    end else begin
      col_next = col_e + CW'(1);
      row_next = row_e;
    end
    sw_s     = $signed(XW'(SCREEN_W));
    ox       = XW'(origin_x);
    far      = (ox >= sw_s) || (ox <= -sw_s);
    code_ok  = (pixel_code < PALETTE_ENTRIES);
    idx_ok   = (palette_index < PALETTE_ENTRIES);
    rd_addr  = PIW'(pixel_code);
    wr_addr  = PIW'(palette_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      col       <= '0;
      row       <= '0;
      pal_valid <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (psub_pkg::cfg_reg_t'(cfg_index))
          psub_pkg::REG_ORIGIN_X: origin_x <= $signed(cfg_data[psub_pkg::ORIGIN_X_W-1:0]);
          psub_pkg::REG_ORIGIN_Y: origin_y <= $signed(cfg_data[psub_pkg::ORIGIN_Y_W-1:0]);
        endcase
      end
      s1_valid <= 1'b0;
      if (accept) begin
        unique case (kind)
          psub_pkg::FUNC_CLEAR: pal_valid <= '0;
          psub_pkg::FUNC_ENTRY: begin
            if (idx_ok) pal_valid[wr_addr] <= 1'b1;
          end
          psub_pkg::FUNC_PIXEL: begin
            if (!past) begin
              col      <= col_next;
              row      <= row_next;
              s1_valid <= !far && code_ok;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == psub_pkg::FUNC_ENTRY && idx_ok) begin
      palette[wr_addr] <= {red, green, blue};
    end
    if (accept) begin
      s1_col <= col_e;
      s1_row <= row_e;
      if (code_ok) begin
        s1_rgb    <= palette[rd_addr];
        s1_pal_ok <= pal_valid[rd_addr];
      end else begin
        s1_rgb    <= '0;
        s1_pal_ok <= 1'b0;
      end
    end
  end

  always_comb begin
    bx0     = XW'($signed({1'b0, s1_col, 1'b0})) + XW'(origin_x);
    bx1     = bx0 + $signed(XW'(1));
    by0     = YW'($signed({1'b0, s1_row, 1'b0})) + YW'(origin_y);
    by1     = by0 + $signed(YW'(1));
    x0_in   = !bx0[XW-1] && (bx0 < $signed(XW'(SCREEN_W)));
    x1_in   = !bx1[XW-1] && (bx1 < $signed(XW'(SCREEN_W)));
    y0_in   = !by0[YW-1] && (by0 < $signed(YW'(SCREEN_H)));
    y1_in   = !by1[YW-1] && (by1 < $signed(YW'(SCREEN_H)));
    mask                       = '0;
    mask[psub_pkg::TGT_X0_Y0]  = x0_in && y0_in;
    mask[psub_pkg::TGT_X1_Y0]  = x1_in && y0_in;
    mask[psub_pkg::TGT_X0_Y1]  = x0_in && y1_in;
    mask[psub_pkg::TGT_X1_Y1]  = x1_in && y1_in;
    base    = PW'(by0) * $signed(PW'(SCREEN_W)) + PW'(bx0);
    visible = s1_pal_ok && (s1_rgb != '0);
    q_push        = s1_valid && visible && (mask != '0);
    q_entry.addr  = base[psub_pkg::ADDR_W-1:0];
    q_entry.rgb   = s1_rgb;
    q_entry.mask  = mask;
  end

endmodule

/* design/psub_queue.sv */
// Short queue of clipped pixel entries between the front and back ends.
// Uses psub_pkg for the entry layout and depth.
module psub_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  psub_pkg::blit_entry_t         push_entry,
  input  logic                          pop,
  output psub_pkg::blit_entry_t         head,
  output logic                          empty,
  output logic [psub_pkg::QLVL_W-1:0]   level
);

  psub_pkg::blit_entry_t            slots [psub_pkg::QUEUE_DEPTH];
  logic [psub_pkg::QPTR_W-1:0]      wptr;
  logic [psub_pkg::QPTR_W-1:0]      rptr;

  assign head  = slots[rptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) wptr <= wptr + psub_pkg::QPTR_W'(1);
      if (pop)  rptr <= rptr + psub_pkg::QPTR_W'(1);
      level <= level + psub_pkg::QLVL_W'(push) - psub_pkg::QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

endmodule

/* design/psub_back.sv */
// Back end: expands one queue entry into its frame-buffer words, one a cycle
// unless fb_ready stalls, behind an output register. Uses psub_pkg.
module psub_back #(
  parameter int SCREEN_W = 160
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psub_pkg::blit_entry_t         head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          fb_valid,
  input  logic                          fb_ready,
  output logic [psub_pkg::ADDR_W-1:0]   fb_address,
  output logic [psub_pkg::CHAN_W-1:0]   out_red,
  output logic [psub_pkg::CHAN_W-1:0]   out_green,
  output logic [psub_pkg::CHAN_W-1:0]   out_blue,
  output logic                          last
);

  logic                          cur_valid;
  logic [psub_pkg::ADDR_W-1:0]   cur_addr;
  logic [psub_pkg::RGB_W-1:0]    cur_rgb;
  logic [psub_pkg::TGT_N-1:0]    cur_rem;
  logic [psub_pkg::TGT_N-1:0]    sel;
  logic [psub_pkg::TGT_N-1:0]    rem_after;
  logic [psub_pkg::ADDR_W-1:0]   offset;
  logic                          emit;
  logic                          done;

  always_comb begin
    sel    = '0;
    offset = '0;
    priority if (cur_rem[psub_pkg::TGT_X0_Y0]) begin
      sel[psub_pkg::TGT_X0_Y0] = 1'b1;
    end else if (cur_rem[psub_pkg::TGT_X1_Y0]) begin
      sel[psub_pkg::TGT_X1_Y0] = 1'b1;
      offset = psub_pkg::ADDR_W'(1);
    end else if (cur_rem[psub_pkg::TGT_X0_Y1]) begin
      sel[psub_pkg::TGT_X0_Y1] = 1'b1;
      offset = psub_pkg::ADDR_W'(SCREEN_W);
    end else begin
      sel[psub_pkg::TGT_X1_Y1] = 1'b1;
      offset = psub_pkg::ADDR_W'(SCREEN_W + 1);
    end
    rem_after = cur_rem & ~sel;
    emit      = cur_valid && (!fb_valid || fb_ready);
    done      = emit && (rem_after == '0);
    pop       = !empty && (!cur_valid || done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_rem   <= '0;
      fb_valid  <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        cur_rem   <= head.mask;
      end else if (emit) begin
        cur_valid <= !done;
        cur_rem   <= rem_after;
      end
      if (emit) fb_valid <= 1'b1;
      else if (fb_ready) fb_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= head.addr;
      cur_rgb  <= head.rgb;
    end
    if (emit) begin
      fb_address <= cur_addr + offset;
      out_red    <= cur_rgb[3*psub_pkg::CHAN_W-1:2*psub_pkg::CHAN_W];
      out_green  <= cur_rgb[2*psub_pkg::CHAN_W-1:psub_pkg::CHAN_W];
      out_blue   <= cur_rgb[psub_pkg::CHAN_W-1:0];
      last       <= (rem_after == '0);
    end
  end

endmodule

/* design/palette_sprite_upscale_blitter_top.sv */
// Top level of the palette sprite blitter with 2x2 upscaling; uses psub_pkg.
// Path of a pixel word: stage-1 registers, queue, back-end entry register, output register.
// Throughput: one input word a cycle while the queue has room; a pixel emits up to 4
// words at one a cycle unless stalled, so drawn pixels are bound by the single output port.
// Reset: synchronous; position, origins and palette valid bits clear (palette reads black).
module palette_sprite_upscale_blitter_top #(
  parameter int SCREEN_W        = 160,
  parameter int SCREEN_H        = 80,
  parameter int SOURCE_W        = 80,
  parameter int SOURCE_H        = 40,
  parameter int PALETTE_ENTRIES = 40
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [1:0]                      func,
  input  logic [5:0]                      palette_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic [7:0]                      pixel_code,
  input  logic                            frame_start,
  input  logic                            cfg_write,
  input  logic [psub_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psub_pkg::CFG_W-1:0]      cfg_data,
  output logic                            fb_valid,
  input  logic                            fb_ready,
  output logic [13:0]                     fb_address,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            last
);

  logic                          q_push;
  psub_pkg::blit_entry_t         q_entry;
  psub_pkg::blit_entry_t         q_head;
  logic                          q_empty;
  logic                          q_pop;
  logic [psub_pkg::QLVL_W-1:0]   q_level;

  psub_front #(
    .SCREEN_W        (SCREEN_W),
    .SCREEN_H        (SCREEN_H),
    .SOURCE_W        (SOURCE_W),
    .SOURCE_H        (SOURCE_H),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .func          (func),
    .palette_index (palette_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .pixel_code    (pixel_code),
    .frame_start   (frame_start),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_level       (q_level),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  psub_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .level      (q_level)
  );

  psub_back #(
    .SCREEN_W (SCREEN_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .fb_valid   (fb_valid),
    .fb_ready   (fb_ready),
    .fb_address (fb_address),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .last       (last)
  );

endmodule

/* verif/palette_sprite_upscale_blitter_top_tb.sv */
// Self-checking testbench for palette_sprite_upscale_blitter_top: palette ops, clipping, frames.
// Predicts frame-buffer words from its own palette and origin copy; depends on psub_pkg.
`timescale 1ns / 100ps

module palette_sprite_upscale_blitter_top_tb;

  localparam int SCR_W       = 160;
  localparam int SCR_H       = 80;
  localparam int SRC_W       = 80;
  localparam int SRC_H       = 40;
  localparam int SRC_PIXELS  = SRC_W * SRC_H;
  localparam int FRAME_SLICE = SRC_W + 4;
  localparam int PAL_N       = 40;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] func;
    logic [5:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pixel_code;
    logic       frame_start;
  } blit_word_t;

  typedef struct {
    logic [13:0] addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } fb_word_t;

  logic                           clk;
  logic                           rst;
  logic                           item_valid;
  logic                           item_ready;
  logic [1:0]                     func;
  logic [5:0]                     palette_index;
  logic [7:0]                     red;
  logic [7:0]                     green;
  logic [7:0]                     blue;
  logic [7:0]                     pixel_code;
  logic                           frame_start;
  logic                           cfg_write;
  logic [psub_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [psub_pkg::CFG_W-1:0]     cfg_data;
  logic                           fb_valid;
  logic                           fb_ready;
  logic [13:0]                    fb_address;
  logic [7:0]                     out_red;
  logic [7:0]                     out_green;
  logic [7:0]                     out_blue;
  logic                           last;

  logic [23:0] pal_shadow [PAL_N];
  int          src_pos = 0;
  int          org_x = 0;
  int          org_y = 0;
  fb_word_t    fb_writes_due [$];
  bit          idle_on = 1'b0;
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          fb_words_seen = 0;
  int          cycle_count = 0;

  palette_sprite_upscale_blitter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .func          (func),
    .palette_index (palette_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .pixel_code    (pixel_code),
    .frame_start   (frame_start),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fb_valid      (fb_valid),
    .fb_ready      (fb_ready),
    .fb_address    (fb_address),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .last          (last)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (pal_shadow[i]) pal_shadow[i] = '0;
  end

  function automatic blit_word_t noise_word();
    blit_word_t w;
    w.func          = 2'($urandom);
    w.palette_index = 6'($urandom);
    w.red           = 8'($urandom);
    w.green         = 8'($urandom);
    w.blue          = 8'($urandom);
    w.pixel_code    = 8'($urandom);
    w.frame_start   = 1'($urandom);
    return w;
  endfunction

  function automatic blit_word_t entry_word(input logic [5:0] idx, input logic [23:0] rgb);
    blit_word_t w;
    w = noise_word();
    w.func = psub_pkg::FUNC_ENTRY;
    w.palette_index = idx;
    {w.red, w.green, w.blue} = rgb;
    return w;
  endfunction

  function automatic blit_word_t pixel_word(input logic [7:0] code, input logic fs);
    blit_word_t w;
    w = noise_word();
    w.func = psub_pkg::FUNC_PIXEL;
    w.pixel_code = code;
    w.frame_start = fs;
    return w;
  endfunction

  function automatic logic [23:0] bright_rgb();
    return 24'($urandom) | 24'h000001;
  endfunction

  // Update the palette and position copy and queue the writes this word causes.
  task automatic compute_fb_writes(input blit_word_t w);
    fb_word_t    f;
    logic [23:0] rgb;
    int          pos;
    int          bx;
    int          by;
    int          px;
    int          py;
    int          depth0;
    case (w.func)
      psub_pkg::FUNC_CLEAR: foreach (pal_shadow[i]) pal_shadow[i] = '0;
      psub_pkg::FUNC_ENTRY: if (w.palette_index < PAL_N)
        pal_shadow[w.palette_index] = {w.red, w.green, w.blue};
      psub_pkg::FUNC_PIXEL: begin
        if (w.frame_start) src_pos = 0;
        if (src_pos < SRC_PIXELS) begin
          pos = src_pos;
          src_pos = src_pos + 1;
          rgb = (w.pixel_code < PAL_N) ? pal_shadow[w.pixel_code] : '0;
          if (org_x < SCR_W && org_x > -SCR_W && rgb != '0) begin
            bx = (pos % SRC_W) * 2 + org_x;
            by = (pos / SRC_W) * 2 + org_y;
            depth0 = fb_writes_due.size();
            for (int dy = 0; dy < 2; dy++) begin
              for (int dx = 0; dx < 2; dx++) begin
                px = bx + dx;
                py = by + dy;
                if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
                  f.addr = 14'(px + py * SCR_W);
                  {f.red, f.green, f.blue} = rgb;
                  f.last = 1'b0;
                  fb_writes_due.push_back(f);
                end
              end
            end
            if (fb_writes_due.size() > depth0) fb_writes_due[$].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Enter and leave at a falling edge; valid stays high for a back-to-back word.
  task automatic send_word(input blit_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid    = 1'b1;
    func          = w.func;
    palette_index = w.palette_index;
    red           = w.red;
    green         = w.green;
    blue          = w.blue;
    pixel_code    = w.pixel_code;
    frame_start   = w.frame_start;
    do @(posedge clk); while (item_ready !== 1'b1);
    compute_fb_writes(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    item_valid = 1'b0;
    while (fb_writes_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input psub_pkg::cfg_reg_t idx,
                           input logic [psub_pkg::CFG_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == psub_pkg::REG_ORIGIN_X) begin
      org_x = int'($signed(data[psub_pkg::ORIGIN_X_W-1:0]));
    end else begin
      org_y = int'($signed(data[psub_pkg::ORIGIN_Y_W-1:0]));
    end
  endtask

  task automatic set_origin(input int ox, input int oy);
    logic [psub_pkg::CFG_W-1:0] ydata;
    wait_drain();
    ydata = {1'($urandom), 8'(oy)};
    write_reg(psub_pkg::REG_ORIGIN_X, 9'(ox));
    write_reg(psub_pkg::REG_ORIGIN_Y, ydata);
  endtask

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: fb %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : fb_monitor
    int       stall;
    fb_word_t want;
    fb_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        fb_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      fb_ready = 1'b1;
      do @(posedge clk); while (fb_valid !== 1'b1);
      fb_words_seen++;
      if (fb_writes_due.size() == 0) begin
        $display("%0t: fb word, expected none, actual addr %0h rgb %h%h%h last %b",
                 $time, fb_address, out_red, out_green, out_blue, last);
        mismatch_count++;
      end else begin
        want = fb_writes_due.pop_front();
        check_field("address", want.addr, fb_address);
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("last", want.last, last);
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached, %0d fb words still due", $time, fb_writes_due.size());
    $display("palette_sprite_upscale_blitter_top_tb: done, errors");
    $finish;
  end

  task automatic test_reset_state();
    idle_on = 1'b0;
    send_word(pixel_word(8'd0, 1'b1));
    send_word(pixel_word(8'd17, 1'b0));
  endtask

  task automatic test_palette_ops();
    blit_word_t w;
    idle_on = 1'b1;
    send_word(entry_word(6'd0, 24'hFFFFFF));
    send_word(entry_word(6'd39, 24'h010000));
    send_word(entry_word(6'd40, 24'h123456));
    send_word(entry_word(6'd63, 24'hFFFFFF));
    send_word(entry_word(6'd7, 24'h000000));
    send_word(pixel_word(8'd0, 1'b1));
    send_word(pixel_word(8'd39, 1'b0));
    send_word(pixel_word(8'd40, 1'b0));
    send_word(pixel_word(8'd255, 1'b0));
    send_word(pixel_word(8'd7, 1'b0));
    w = noise_word();
    w.func = FUNC_UNUSED;
    w.frame_start = 1'b1;
    send_word(w);
    send_word(pixel_word(8'd0, 1'b0));
    w = entry_word(6'd12, 24'h00FF00);
    w.frame_start = 1'b1;
    send_word(w);
    send_word(pixel_word(8'd12, 1'b0));
  endtask

  task automatic test_palette_clear();
    blit_word_t w;
    w = noise_word();
    w.func = psub_pkg::FUNC_CLEAR;
    w.frame_start = 1'b1;
    send_word(w);
    send_word(pixel_word(8'd0, 1'b0));
    send_word(pixel_word(8'd39, 1'b0));
  endtask

  task automatic test_origin_clipping();
    int ox [5] = '{-1, 159, 160, -160, -159};
    int oy [5] = '{-1, 79, 0, 127, -128};
    send_word(entry_word(6'd5, bright_rgb()));
    foreach (ox[i]) begin
      set_origin(ox[i], oy[i]);
      send_word(pixel_word(8'd5, 1'b1));
      send_word(pixel_word(8'd5, 1'b0));
    end
  endtask

  // Two frame starts, each running past the first row wrap, then a restart.
  task automatic test_frame_slices();
    logic [7:0] code;
    set_origin(0, 0);
    send_word(entry_word(6'd0, 24'h000000));
    for (int e = 1; e < 8; e++) send_word(entry_word(6'(e), bright_rgb()));
    for (int f = 0; f < 2; f++) begin
      if (f == 1) set_origin(1, 1);
      idle_on = (f == 0);
      for (int i = 0; i < FRAME_SLICE; i++) begin
        if (i == SRC_W - 1 || $urandom_range(0, 2) == 0) code = 8'($urandom_range(1, 7));
        else if ($urandom_range(0, 1) == 0) code = 8'd0;
        else code = 8'($urandom_range(40, 255));
        send_word(pixel_word(code, i == 0));
      end
      for (int i = 0; i < 3; i++) send_word(pixel_word(8'($urandom_range(1, 7)), 1'b0));
      send_word(pixel_word(8'($urandom_range(1, 7)), 1'b1));
    end
  endtask

  task automatic test_random_traffic();
    blit_word_t w;
    int         pick;
    for (int e = 0; e < 8; e++) begin
      send_word(entry_word(6'($urandom_range(0, PAL_N - 1)), bright_rgb()));
    end
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_origin(0, 0);
        1: set_origin(-159, -128);
        2: set_origin(159, 127);
        3: set_origin($urandom_range(0, 511) - 256, $urandom_range(0, 255) - 128);
        4: set_origin(-int'($urandom_range(0, 12)), -int'($urandom_range(0, 12)));
        default: set_origin($urandom_range(0, 318) - 159, $urandom_range(0, 100) - 50);
      endcase
      idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      send_word(pixel_word(8'($urandom_range(0, PAL_N - 1)), 1'b1));
      for (int i = 0; i < 15; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          w = noise_word();
          w.func = psub_pkg::FUNC_CLEAR;
        end else if (pick < 5) begin
          w = noise_word();
          w.func = FUNC_UNUSED;
        end else if (pick < 25) begin
          w = entry_word(6'($urandom_range(0, PAL_N - 1)),
                         ($urandom_range(0, 9) == 0) ? 24'h0 : bright_rgb());
          if ($urandom_range(0, 6) == 0) w.palette_index = 6'($urandom_range(PAL_N, 63));
        end else begin
          w = pixel_word(($urandom_range(0, 7) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, PAL_N - 1)), $urandom_range(0, 19) == 0);
        end
        send_word(w);
        if ($urandom_range(0, 29) == 0) wait_drain();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    func          = psub_pkg::FUNC_CLEAR;
    palette_index = '0;
    red           = '0;
    green         = '0;
    blue          = '0;
    pixel_code    = '0;
    frame_start   = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = psub_pkg::REG_ORIGIN_X;
    cfg_data      = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_palette_ops();
    test_palette_clear();
    test_origin_clipping();
    test_frame_slices();
    test_random_traffic();
    wait_drain();
    $display("Sent %0d input words; checked %0d frame-buffer words in %0d cycles.",
             words_sent, fb_words_seen, cycle_count);
    $display("Covered palette ops, edge clipping, far origins, row wraps, random mixes.");
    if (mismatch_count == 0) begin
      $display("palette_sprite_upscale_blitter_top_tb: done, clean");
    end else begin
      $display("palette_sprite_upscale_blitter_top_tb: done, errors");
    end
    $finish;
  end

endmodule
